FILE: sv/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared constants, codes and types of the disk request scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

    localparam int MAX_REQUESTS  = 64;
    localparam int CYLINDER_BITS = 16;

    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int CYL_W = CYLINDER_BITS;
    localparam int ARR_W = 32;
    localparam int ENT_W = ARR_W + CYL_W;
    // arrival plus the total of all seeks of one batch
    localparam int CLK_W = ((ARR_W > CYL_W + IDX_W) ? ARR_W : CYL_W + IDX_W) + 1;

    typedef enum logic [1:0] {
        POL_FCFS  = 2'd0,
        POL_SSTF  = 2'd1,
        POL_LOOK  = 2'd2,
        POL_CLOOK = 2'd3
    } policy_t;

    typedef enum logic {
        REG_POLICY = 1'b0,
        REG_START  = 1'b1
    } reg_index_t;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_GROW_RD  = 7'b0000010,
        ST_GROW_CMP = 7'b0000100,
        ST_SCAN     = 7'b0001000,
        ST_DECIDE   = 7'b0010000,
        ST_FETCH    = 7'b0100000,
        ST_COMMIT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic             v;
        logic [IDX_W-1:0] idx;
        logic [CYL_W-1:0] d;
    } cand_t;

endpackage

`default_nettype wire

FILE: sv/drs_ram.sv
// ----------------------------------------------------------------------------
// drs_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/disk_request_scheduler_top.sv
// ----------------------------------------------------------------------------
// disk_request_scheduler_top
// Loading: one item per cycle into the request RAM; no result.
// Run: FCFS fetches each entry from the RAM and commits it. Other policies grow
// the pending prefix, scan it through the single RAM read port, then decide,
// fetch and commit. Commit holds while the output register is still full.
// Reset: idle, empty store, policy FCFS, start cylinder 1; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_request_scheduler_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    // request items
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] arrival_time,
    input  wire logic [15:0] cylinder,
    input  wire logic        last,
    // service result items
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       request_index,
    output logic [32:0]      wait_time,
    output logic [21:0]      total_movement,
    output logic             final_res
);

    localparam int IDX_W = drs_pkg::IDX_W;
    localparam int CNT_W = drs_pkg::CNT_W;
    localparam int CYL_W = drs_pkg::CYL_W;
    localparam int ARR_W = drs_pkg::ARR_W;
    localparam int ENT_W = drs_pkg::ENT_W;
    localparam int CLK_W = drs_pkg::CLK_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    drs_pkg::state_t  state_reg,    state_next;
    drs_pkg::policy_t policy_reg,   policy_next;
    logic [15:0]      start_reg,    start_next;

    logic [CNT_W-1:0] loaded_cnt_reg, loaded_cnt_next;   // batch size n
    logic [CNT_W-1:0] served_cnt_reg, served_cnt_next;
    logic [CNT_W-1:0] prefix_reg,     prefix_next;       // pending prefix
    logic [CNT_W-1:0] scan_addr_reg,  scan_addr_next;
    logic [CLK_W-1:0] clock_reg,      clock_next;
    logic [CYL_W-1:0] head_reg,       head_next;
    logic             sweep_up_reg,   sweep_up_next;
    logic [21:0]      movement_reg,   movement_next;
    logic [drs_pkg::MAX_REQUESTS-1:0] served_flags_reg, served_flags_next;

    logic             rd_valid_reg,  rd_valid_next;      // scan data in flight
    logic [IDX_W-1:0] rd_idx_reg,    rd_idx_next;
    logic [IDX_W-1:0] pick_idx_reg,  pick_idx_next;

    drs_pkg::cand_t any_reg,   any_next;
    drs_pkg::cand_t left_reg,  left_next;
    drs_pkg::cand_t right_reg, right_next;
    drs_pkg::cand_t same_reg,  same_next;

    logic             out_valid_reg,  out_valid_next;
    logic [5:0]       req_idx_reg,    req_idx_next;
    logic [32:0]      wait_reg,       wait_next;
    logic [21:0]      total_mv_reg,   total_mv_next;
    logic             final_reg,      final_next;

    // ------------------------------------------------------------------
    // Request RAM: {arrival, cylinder} per entry
    // ------------------------------------------------------------------
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    drs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (drs_pkg::MAX_REQUESTS)
    ) u_req_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [ARR_W-1:0] rd_arr;
    logic [CYL_W-1:0] rd_cyl;
    logic [CLK_W-1:0] rd_arr_ext;

    assign rd_arr     = ram_rdata[ENT_W-1:CYL_W];
    assign rd_cyl     = ram_rdata[CYL_W-1:0];
    assign rd_arr_ext = CLK_W'(rd_arr);

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_fire;
    logic batch_start;
    logic commit_fire;
    logic last_serve;

    assign cfg_ready   = (state_reg == drs_pkg::ST_IDLE);
    assign in_ready    = (state_reg == drs_pkg::ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    // the final slot of the store closes the batch as if last were set
    assign batch_start = in_fire &&
        (last || (loaded_cnt_reg + CNT_W'(1) == CNT_W'(drs_pkg::MAX_REQUESTS)));
    assign commit_fire = (state_reg == drs_pkg::ST_COMMIT) &&
                         (!out_valid_reg || out_ready);

    logic [CNT_W-1:0] served_inc;
    assign served_inc = served_cnt_reg + CNT_W'(1);
    assign last_serve = (served_inc == loaded_cnt_reg);

    assign ram_we    = in_fire;
    assign ram_waddr = loaded_cnt_reg[IDX_W-1:0];
    assign ram_wdata = {arrival_time, CYL_W'(cylinder)};

    // ------------------------------------------------------------------
    // Scan datapath: distance from the head to the entry just read
    // ------------------------------------------------------------------
    logic [CYL_W-1:0] scan_d;
    logic             scan_below;
    logic             scan_above;
    logic             scan_live;

    assign scan_below = (rd_cyl < head_reg);
    assign scan_above = (rd_cyl > head_reg);
    assign scan_d     = scan_below ? (head_reg - rd_cyl) : (rd_cyl - head_reg);
    assign scan_live  = rd_valid_reg && !served_flags_reg[rd_idx_reg];

    // ------------------------------------------------------------------
    // Commit datapath: the clock waits for the arrival under FCFS; for the
    // other policies the entry has already arrived, so the max is a no-op
    // ------------------------------------------------------------------
    logic [CLK_W-1:0] clk_eff;
    logic [CYL_W-1:0] seek_d;

    assign clk_eff = (clock_reg > rd_arr_ext) ? clock_reg : rd_arr_ext;
    assign seek_d  = (rd_cyl < head_reg) ? (head_reg - rd_cyl) : (rd_cyl - head_reg);

    // ------------------------------------------------------------------
    // Control and next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        policy_next       = policy_reg;
        start_next        = start_reg;
        loaded_cnt_next   = loaded_cnt_reg;
        served_cnt_next   = served_cnt_reg;
        prefix_next       = prefix_reg;
        scan_addr_next    = scan_addr_reg;
        clock_next        = clock_reg;
        head_next         = head_reg;
        sweep_up_next     = sweep_up_reg;
        movement_next     = movement_reg;
        served_flags_next = served_flags_reg;
        rd_valid_next     = 1'b0;
        rd_idx_next       = rd_idx_reg;
        pick_idx_next     = pick_idx_reg;
        any_next          = any_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        same_next         = same_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        req_idx_next      = req_idx_reg;
        wait_next         = wait_reg;
        total_mv_next     = total_mv_reg;
        final_next        = final_reg;
        ram_re            = 1'b0;
        ram_raddr         = '0;

        // configuration is only written while idle
        if (cfg_valid && cfg_ready)
        begin
            case (drs_pkg::reg_index_t'(cfg_index))
                drs_pkg::REG_POLICY: policy_next = drs_pkg::policy_t'(cfg_data[1:0]);
                drs_pkg::REG_START:  start_next  = cfg_data;
                default:             ;
            endcase
        end

        case (state_reg)
            drs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    loaded_cnt_next = loaded_cnt_reg + CNT_W'(1);
                end
                if (batch_start)
                begin
                    // start a run from the programmed cylinder
                    clock_next      = '0;
                    head_next       = CYL_W'(start_reg);
                    sweep_up_next   = 1'b1;
                    movement_next   = '0;
                    prefix_next     = '0;
                    served_cnt_next = '0;
                    pick_idx_next   = '0;
                    if (policy_reg == drs_pkg::POL_FCFS)
                    begin
                        state_next = drs_pkg::ST_FETCH;
                    end
                    else
                    begin
                        state_next = drs_pkg::ST_GROW_RD;
                    end
                end
            end

            drs_pkg::ST_GROW_RD:
            begin
                if (prefix_reg < loaded_cnt_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = prefix_reg[IDX_W-1:0];
                    state_next = drs_pkg::ST_GROW_CMP;
                end
                else
                begin
                    scan_addr_next = '0;
                    any_next       = '0;
                    left_next      = '0;
                    right_next     = '0;
                    same_next      = '0;
                    state_next     = drs_pkg::ST_SCAN;
                end
            end

            drs_pkg::ST_GROW_CMP:
            begin
                // extend the prefix; with nothing pending, jump the clock
                // to the next arrival and take that entry too
                if (rd_arr_ext <= clock_reg || served_cnt_reg == prefix_reg)
                begin
                    if (rd_arr_ext > clock_reg)
                    begin
                        clock_next = rd_arr_ext;
                    end
                    prefix_next = prefix_reg + CNT_W'(1);
                    state_next  = drs_pkg::ST_GROW_RD;
                end
                else
                begin
                    scan_addr_next = '0;
                    any_next       = '0;
                    left_next      = '0;
                    right_next     = '0;
                    same_next      = '0;
                    state_next     = drs_pkg::ST_SCAN;
                end
            end

            drs_pkg::ST_SCAN:
            begin
                // issue one read a cycle, evaluate the entry of last cycle
                if (scan_addr_reg < prefix_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = scan_addr_reg[IDX_W-1:0];
                    rd_valid_next  = 1'b1;
                    rd_idx_next    = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
                else if (!rd_valid_reg)
                begin
                    state_next = drs_pkg::ST_DECIDE;
                end

                if (scan_live)
                begin
                    // strict compares keep the lowest index on ties
                    if (!any_reg.v || scan_d < any_reg.d)
                    begin
                        any_next = '{v: 1'b1, idx: rd_idx_reg, d: scan_d};
                    end
                    if (scan_below)
                    begin
                        if (!left_reg.v ||
                            ((policy_reg == drs_pkg::POL_CLOOK) ? (scan_d > left_reg.d)
                                                                : (scan_d < left_reg.d)))
                        begin
                            left_next = '{v: 1'b1, idx: rd_idx_reg, d: scan_d};
                        end
                    end
                    else if (scan_above)
                    begin
                        if (!right_reg.v || scan_d < right_reg.d)
                        begin
                            right_next = '{v: 1'b1, idx: rd_idx_reg, d: scan_d};
                        end
                    end
                    else if (!same_reg.v)
                    begin
                        same_next = '{v: 1'b1, idx: rd_idx_reg, d: scan_d};
                    end
                end
            end

            drs_pkg::ST_DECIDE:
            begin
                state_next = drs_pkg::ST_FETCH;
                if (policy_reg == drs_pkg::POL_SSTF)
                begin
                    pick_idx_next = any_reg.idx;
                end
                else if (same_reg.v)
                begin
                    pick_idx_next = same_reg.idx;
                end
                else if (policy_reg == drs_pkg::POL_LOOK && !sweep_up_reg)
                begin
                    if (left_reg.v)
                    begin
                        pick_idx_next = left_reg.idx;
                    end
                    else
                    begin
                        sweep_up_next = 1'b1;
                        pick_idx_next = right_reg.idx;
                    end
                end
                else if (right_reg.v)
                begin
                    pick_idx_next = right_reg.idx;
                end
                else
                begin
                    // LOOK turns around; C-LOOK wraps to the far left entry
                    if (policy_reg == drs_pkg::POL_LOOK)
                    begin
                        sweep_up_next = 1'b0;
                    end
                    pick_idx_next = left_reg.idx;
                end
            end

            drs_pkg::ST_FETCH:
            begin
                ram_re     = 1'b1;
                ram_raddr  = pick_idx_reg;
                state_next = drs_pkg::ST_COMMIT;
            end

            drs_pkg::ST_COMMIT:
            begin
                // hold until the output register is free
                if (commit_fire)
                begin
                    out_valid_next  = 1'b1;
                    req_idx_next    = 6'(pick_idx_reg);
                    wait_next       = 33'(clk_eff - rd_arr_ext);
                    total_mv_next   = movement_reg + 22'(seek_d);
                    final_next      = last_serve;
                    movement_next   = movement_reg + 22'(seek_d);
                    clock_next      = clk_eff + CLK_W'(seek_d);
                    head_next       = rd_cyl;
                    served_cnt_next = served_inc;
                    served_flags_next[pick_idx_reg] = 1'b1;
                    if (last_serve)
                    begin
                        // drop the batch and reopen for loading
                        loaded_cnt_next   = '0;
                        served_flags_next = '0;
                        state_next        = drs_pkg::ST_IDLE;
                    end
                    else if (policy_reg == drs_pkg::POL_FCFS)
                    begin
                        pick_idx_next = served_inc[IDX_W-1:0];
                        state_next    = drs_pkg::ST_FETCH;
                    end
                    else
                    begin
                        state_next = drs_pkg::ST_GROW_RD;
                    end
                end
            end

            default:
            begin
                state_next = drs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= drs_pkg::ST_IDLE;
            policy_reg       <= drs_pkg::POL_FCFS;
            start_reg        <= 16'd1;
            loaded_cnt_reg   <= '0;
            served_cnt_reg   <= '0;
            prefix_reg       <= '0;
            scan_addr_reg    <= '0;
            clock_reg        <= '0;
            head_reg         <= CYL_W'(1);
            sweep_up_reg     <= 1'b1;
            movement_reg     <= '0;
            served_flags_reg <= '0;
            rd_valid_reg     <= 1'b0;
            rd_idx_reg       <= '0;
            pick_idx_reg     <= '0;
            any_reg          <= '0;
            left_reg         <= '0;
            right_reg        <= '0;
            same_reg         <= '0;
            out_valid_reg    <= 1'b0;
            req_idx_reg      <= '0;
            wait_reg         <= '0;
            total_mv_reg     <= '0;
            final_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            policy_reg       <= policy_next;
            start_reg        <= start_next;
            loaded_cnt_reg   <= loaded_cnt_next;
            served_cnt_reg   <= served_cnt_next;
            prefix_reg       <= prefix_next;
            scan_addr_reg    <= scan_addr_next;
            clock_reg        <= clock_next;
            head_reg         <= head_next;
            sweep_up_reg     <= sweep_up_next;
            movement_reg     <= movement_next;
            served_flags_reg <= served_flags_next;
            rd_valid_reg     <= rd_valid_next;
            rd_idx_reg       <= rd_idx_next;
            pick_idx_reg     <= pick_idx_next;
            any_reg          <= any_next;
            left_reg         <= left_next;
            right_reg        <= right_next;
            same_reg         <= same_next;
            out_valid_reg    <= out_valid_next;
            req_idx_reg      <= req_idx_next;
            wait_reg         <= wait_next;
            total_mv_reg     <= total_mv_next;
            final_reg        <= final_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign request_index  = req_idx_reg;
    assign wait_time      = wait_reg;
    assign total_movement = total_mv_reg;
    assign final_res      = final_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_scan_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == drs_pkg::ST_SCAN |-> served_cnt_reg < prefix_reg)
        else $error("scan started with no pending request");

    a_no_double_serve: assert property (@(posedge clk) disable iff (!rst_n)
        commit_fire |-> !served_flags_reg[pick_idx_reg])
        else $error("request served twice");

    a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit_fire && last_serve |=> state_reg == drs_pkg::ST_IDLE && final_reg)
        else $error("final result did not close the run");

    a_idle_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == drs_pkg::ST_IDLE |-> served_flags_reg == '0)
        else $error("served flags left set between runs");

endmodule

`default_nettype wire

FILE: sim/tb_disk_request_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disk_request_scheduler_top
// Self-checking bench for the disk request scheduler. Request batches go in
// over the valid/ready request port, and the bench replays each batch on its
// own model of the head under the active policy. Every service result that
// comes out is compared field by field, in order, against that model. A short
// table of hand-picked requests comes first. Random batches follow, run under
// all four policies, several start cylinders and four idling patterns.
// ----------------------------------------------------------------------------

module tb_disk_request_scheduler_top;

    import drs_pkg::*;

    localparam int SETTLE_CYCLES = 250;    // settle time after each drain, in cycles
    localparam int QUIET_LIMIT   = 20000;  // cycles with no handshake before giving up
    localparam int PHASE_ITEMS   = 8;

    // one expected service result
    typedef struct packed {
        logic [5:0]  idx;
        logic [32:0] wait_t;
        logic [21:0] moved;
        logic        fin;
    } service_t;

    // one row of the directed table; typed rows carry their own answer
    typedef struct packed {
        logic        set_cfg;
        policy_t     pol;
        logic [15:0] start;
        logic [31:0] arr;
        logic [15:0] cyl;
        logic        lst;
        logic        typed;
        logic [21:0] move;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] arrival_time = '0;
    logic [15:0] cylinder = '0;
    logic        last = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  request_index;
    logic [32:0] wait_time;
    logic [21:0] total_movement;
    logic        final_res;

    // idling knobs, in percent per cycle
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int mismatch_count = 0;
    int quiet_cycles = 0;

    // expected results, oldest first
    service_t service_q[$];
    service_t want;

    // scheduling model: configuration, request store and head state
    policy_t         cfg_policy = POL_FCFS;
    logic [15:0]     cfg_start = 16'd1;
    logic [31:0]     arr_mem [MAX_REQUESTS];
    logic [15:0]     cyl_mem [MAX_REQUESTS];
    bit              done_flag [MAX_REQUESTS];
    int              n_loaded = 0;
    int              prefix_len;
    longint unsigned sim_clock;
    longint unsigned moved_total;
    logic [15:0]     head_pos;
    bit              sweep_up_dir;

    disk_request_scheduler_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .arrival_time   (arrival_time),
        .cylinder       (cylinder),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .request_index  (request_index),
        .wait_time      (wait_time),
        .total_movement (total_movement),
        .final_res      (final_res)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Scheduling model
    // ------------------------------------------------------------------------

    function automatic longint unsigned seek_distance(input logic [15:0] a,
                                                      input logic [15:0] b);
        return (a > b) ? longint'(a - b) : longint'(b - a);
    endfunction

    // grow the pending set over every leading request that has arrived
    function automatic void extend_prefix();
        while (prefix_len < n_loaded && arr_mem[prefix_len] <= sim_clock)
            prefix_len++;
    endfunction

    // pick the next pending request for shortest seek, LOOK or circular LOOK
    function automatic int choose_request(output longint unsigned seek_len);
        int              i;
        int              any_i, left_i, same_i, right_i;
        longint unsigned any_d, left_d, right_d, d;
        logic [15:0]     c;
        bit              further;
        any_i = -1;
        left_i = -1;
        same_i = -1;
        right_i = -1;
        any_d = 0;
        left_d = 0;
        right_d = 0;
        for (i = 0; i < prefix_len; i++)
        begin
            if (!done_flag[i])
            begin
                c = cyl_mem[i];
                d = seek_distance(head_pos, c);
                if (any_i < 0 || d < any_d)
                begin
                    any_i = i;
                    any_d = d;
                end
                if (c < head_pos)
                begin
                    // circular LOOK wraps to the farthest request below the head
                    further = (cfg_policy == POL_CLOOK) ? (d > left_d) : (d < left_d);
                    if (left_i < 0 || further)
                    begin
                        left_i = i;
                        left_d = d;
                    end
                end
                else if (c > head_pos)
                begin
                    if (right_i < 0 || d < right_d)
                    begin
                        right_i = i;
                        right_d = d;
                    end
                end
                else if (same_i < 0)
                    same_i = i;
            end
        end
        if (cfg_policy == POL_SSTF)
        begin
            seek_len = any_d;
            return (any_i < 0) ? 0 : any_i;
        end
        if (same_i >= 0)
        begin
            seek_len = 0;
            return same_i;
        end
        if (cfg_policy == POL_LOOK && !sweep_up_dir)
        begin
            if (left_i >= 0)
            begin
                seek_len = left_d;
                return left_i;
            end
            sweep_up_dir = 1'b1;
            seek_len = right_d;
            return (right_i < 0) ? 0 : right_i;
        end
        if (right_i >= 0)
        begin
            seek_len = right_d;
            return right_i;
        end
        if (cfg_policy == POL_LOOK)
            sweep_up_dir = 1'b0;
        seek_len = left_d;
        return (left_i < 0) ? 0 : left_i;
    endfunction

    // run the head over the loaded batch and queue one result per service
    function automatic void schedule_batch();
        int              k, idx, served_n;
        longint unsigned d;
        service_t        s;
        sim_clock = 0;
        head_pos = cfg_start;
        sweep_up_dir = 1'b1;
        moved_total = 0;
        prefix_len = 0;
        served_n = 0;
        foreach (done_flag[i])
            done_flag[i] = 1'b0;
        for (k = 0; k < n_loaded; k++)
        begin
            if (cfg_policy == POL_FCFS)
            begin
                idx = k;
                if (sim_clock < arr_mem[idx])
                    sim_clock = arr_mem[idx];
                d = seek_distance(head_pos, cyl_mem[idx]);
            end
            else
            begin
                extend_prefix();
                // nothing pending: jump the clock to the next arrival
                if (served_n == prefix_len && prefix_len < n_loaded)
                begin
                    sim_clock = arr_mem[prefix_len];
                    extend_prefix();
                end
                idx = choose_request(d);
            end
            done_flag[idx] = 1'b1;
            s.idx = 6'(idx);
            s.wait_t = 33'(sim_clock - arr_mem[idx]);
            sim_clock += d;
            moved_total += d;
            s.moved = 22'(moved_total);
            s.fin = (k + 1 == n_loaded);
            service_q.push_back(s);
            head_pos = cyl_mem[idx];
            served_n++;
        end
        n_loaded = 0;
    endfunction

    // load one accepted request; a last mark or a full store starts the run
    function automatic void store_request(input logic [31:0] arr, input logic [15:0] cyl,
                                          input logic lst);
        if (n_loaded < MAX_REQUESTS)
        begin
            arr_mem[n_loaded] = arr;
            cyl_mem[n_loaded] = cyl;
            n_loaded++;
        end
        if (lst || n_loaded >= MAX_REQUESTS)
            schedule_batch();
    endfunction

    // ------------------------------------------------------------------------
    // Port drivers
    // ------------------------------------------------------------------------

    // offer one request item and hold it until accepted; valid stays high on return
    task automatic send_request(input logic [31:0] arr, input logic [15:0] cyl,
                                input logic lst);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        arrival_time <= arr;
        cylinder <= cyl;
        last <= lst;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop the request port, wait for every expected result, then let the block settle
    task automatic wait_drained(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (service_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_POLICY)
            cfg_policy = policy_t'(val[1:0]);
        else
            cfg_start = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // write both registers; the policy write carries random upper bits
    task automatic configure(input policy_t pol, input logic [15:0] start);
        logic [15:0] val;
        val = 16'($urandom);
        val[1:0] = pol;
        write_reg(REG_POLICY, val);
        write_reg(REG_START, start);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
        endcase
    endtask

    // one random batch: arrivals and cylinders drawn from a few shapes so that
    // pending sets, clock jumps, ties and sweeps all turn up
    task automatic random_batch(input int count, input logic end_with_last);
        logic [31:0] t;
        logic [15:0] center, c;
        int          amode, cmode, k;
        amode = $urandom_range(3);
        cmode = $urandom_range(3);
        t = $urandom_range(100);
        center = $urandom_range(1) ? cfg_start : 16'($urandom);
        for (k = 0; k < count; k++)
        begin
            case (amode)
                0: t = ($urandom_range(3) == 0) ? $urandom_range(50) : 0;
                1: t = t + $urandom_range(400);
                2: t = $urandom_range(3000);
                default: t = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(2000);
            endcase
            case (cmode)
                0: c = 16'(center + $urandom_range(400) - 200);
                1: c = 16'($urandom);
                2:
                begin
                    case ($urandom_range(3))
                        0: c = 16'h0000;
                        1: c = 16'hFFFF;
                        2: c = center;
                        default: c = center ^ 16'h0001;
                    endcase
                end
                default: c = 16'(16'd500 + 16'd50 * $urandom_range(8));
            endcase
            send_request(t, c, (k == count - 1) ? end_with_last : 1'b0);
            store_request(t, c, (k == count - 1) ? end_with_last : 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver, result check and watchdog
    // ------------------------------------------------------------------------

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (service_q.size() == 0)
            begin
                $error("unexpected service result: request_index %0d", request_index);
                mismatch_count++;
            end
            else
            begin
                want = service_q.pop_front();
                if (request_index !== want.idx)
                begin
                    $error("request_index: expected %0d, got %0d", want.idx, request_index);
                    mismatch_count++;
                end
                if (wait_time !== want.wait_t)
                begin
                    $error("wait_time: expected %0d, got %0d", want.wait_t, wait_time);
                    mismatch_count++;
                end
                if (total_movement !== want.moved)
                begin
                    $error("total_movement: expected %0d, got %0d", want.moved,
                           total_movement);
                    mismatch_count++;
                end
                if (final_res !== want.fin)
                begin
                    $error("final_res: expected %0d, got %0d", want.fin, final_res);
                    mismatch_count++;
                end
            end
        end
    end

    // end the run if no handshake of any kind happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Directed table
    // Rows with typed set hold a one-request batch whose answer is plain:
    // index 0, no wait, final, and the seek from the start cylinder.
    // ------------------------------------------------------------------------

    plan_row_t plan [23] = '{
        // reset configuration: first come first served from cylinder 1
        '{1'b0, POL_FCFS,  16'd1,     32'd0,          16'd0,     1'b1, 1'b1, 22'd1},
        '{1'b0, POL_FCFS,  16'd1,     32'hFFFF_FFFF,  16'hFFFF,  1'b1, 1'b1, 22'd65534},
        // arrivals out of order under first come first served
        '{1'b1, POL_FCFS,  16'd500,   32'd30,         16'd600,   1'b0, 1'b0, 22'd0},
        '{1'b0, POL_FCFS,  16'd500,   32'd10,         16'd400,   1'b0, 1'b0, 22'd0},
        '{1'b0, POL_FCFS,  16'd500,   32'd10,         16'd500,   1'b1, 1'b0, 22'd0},
        // full seek across the disk
        '{1'b1, POL_SSTF,  16'd0,     32'hFFFF_FFFF,  16'hFFFF,  1'b1, 1'b1, 22'd65535},
        // equal distance on both sides, head's own cylinder, then a clock jump
        '{1'b1, POL_SSTF,  16'd100,   32'd0,          16'd110,   1'b0, 1'b0, 22'd0},
        '{1'b0, POL_SSTF,  16'd100,   32'd0,          16'd90,    1'b0, 1'b0, 22'd0},
        '{1'b0, POL_SSTF,  16'd100,   32'd0,          16'd100,   1'b0, 1'b0, 22'd0},
        '{1'b0, POL_SSTF,  16'd100,   32'd5000,       16'd7,     1'b0, 1'b0, 22'd0},
        '{1'b0, POL_SSTF,  16'd100,   32'd2,          16'd120,   1'b1, 1'b0, 22'd0},
        // LOOK: same cylinder first, up, turn down, jump, turn up again
        '{1'b1, POL_LOOK,  16'd200,   32'd0,          16'd150,   1'b0, 1'b0, 22'd0},
        '{1'b0, POL_LOOK,  16'd200,   32'd0,          16'd250,   1'b0, 1'b0, 22'd0},
        '{1'b0, POL_LOOK,  16'd200,   32'd0,          16'd200,   1'b0, 1'b0, 22'd0},
        '{1'b0, POL_LOOK,  16'd200,   32'd0,          16'd100,   1'b0, 1'b0, 22'd0},
        '{1'b0, POL_LOOK,  16'd200,   32'd900,        16'd300,   1'b1, 1'b0, 22'd0},
        // request already under the head
        '{1'b1, POL_LOOK,  16'd42,    32'd7,          16'd42,    1'b1, 1'b1, 22'd0},
        // circular LOOK wrap from the top cylinder to the bottom one
        '{1'b1, POL_CLOOK, 16'hFFFF,  32'd0,          16'd0,     1'b1, 1'b1, 22'd65535},
        // wrap to the farthest left, with a duplicate cylinder there
        '{1'b1, POL_CLOOK, 16'd1000,  32'd0,          16'd1500,  1'b0, 1'b0, 22'd0},
        '{1'b0, POL_CLOOK, 16'd1000,  32'd0,          16'd300,   1'b0, 1'b0, 22'd0},
        '{1'b0, POL_CLOOK, 16'd1000,  32'd0,          16'd600,   1'b0, 1'b0, 22'd0},
        '{1'b0, POL_CLOOK, 16'd1000,  32'd0,          16'd1200,  1'b0, 1'b0, 22'd0},
        '{1'b0, POL_CLOOK, 16'd1000,  32'd3,          16'd300,   1'b1, 1'b0, 22'd0}
    };

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial
    begin
        int          r, p, phase_items, n;
        logic [15:0] start;
        // hold reset once, then release away from the sampling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // walk the directed table; configure only with the block drained
        for (r = 0; r < $size(plan); r++)
        begin
            if (plan[r].set_cfg)
            begin
                wait_drained(SETTLE_CYCLES);
                configure(plan[r].pol, plan[r].start);
            end
            send_request(plan[r].arr, plan[r].cyl, plan[r].lst);
            if (plan[r].typed)
                service_q.push_back(service_t'{6'd0, 33'd0, plan[r].move, 1'b1});
            else
                store_request(plan[r].arr, plan[r].cyl, plan[r].lst);
        end

        // random phases: each policy runs twice, under two idling patterns
        for (p = 0; p < 8; p++)
        begin
            wait_drained(SETTLE_CYCLES);
            case (p)
                0, 7:    start = 16'h0000;
                1, 5:    start = 16'hFFFF;
                3:       start = 16'd1;
                6:       start = 16'($urandom_range(2000));
                default: start = 16'($urandom);
            endcase
            configure(policy_t'((p + p / 4) % 4), start);
            set_idling(p % 4);
            phase_items = 0;
            // fill the store once so the run starts on the full count alone
            if (p == 6)
                random_batch(MAX_REQUESTS, 1'b0);
            while (phase_items < PHASE_ITEMS)
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                random_batch(n, 1'b1);
                phase_items += n;
                // in the calm phases, sometimes hold the sender until all results are back
                if (p % 4 == 0 && $urandom_range(1) == 1)
                    wait_drained(0);
            end
        end

        // drain, give any stray result time to show, then report
        wait_drained(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
